### sv/ptd_pkg.sv
// Package for the periodic task dispatcher: slot count, field widths and codes.
// No dependencies; imported by the channel interfaces and every module.
package ptd_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int MAX_OUT    = 8;
    localparam int CNT_W      = $clog2(MAX_OUT);

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [1:0]        cmd_t;
    typedef logic [1:0]        mode_t;
    typedef logic [1:0]        status_t;
    typedef logic [31:0]       time_t;
    typedef logic [3:0]        sel_t;
    typedef logic [2:0]        slot_num_t;

    localparam slot_idx_t LAST_IDX = slot_idx_t'(TASK_SLOTS - 1);

    localparam cmd_t CMD_ADD      = 2'd0;
    localparam cmd_t CMD_REMOVE   = 2'd1;
    localparam cmd_t CMD_TICK     = 2'd2;
    localparam cmd_t CMD_DISPATCH = 2'd3;

    localparam mode_t MODE_PERIODIC   = 2'd0;
    localparam mode_t MODE_ONE_SHOT   = 2'd1;
    localparam mode_t MODE_BACKGROUND = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_BAD_SLOT = 2'd2;
    localparam status_t ST_NONE     = 2'd3;

endpackage

### sv/ptd_req_if.sv
// Request channel of the periodic task dispatcher: valid, ready and payload.
// Depends on ptd_pkg for the field types.
interface ptd_req_if
    import ptd_pkg::*;
();
    logic  valid;
    logic  ready;
    cmd_t  cmd;
    time_t now;
    mode_t run_mode;
    time_t task_period;
    sel_t  slot_select;

    modport source (output valid, cmd, now, run_mode, task_period, slot_select,
                    input ready);
    modport sink   (input valid, cmd, now, run_mode, task_period, slot_select,
                    output ready);
endinterface

### sv/ptd_rsp_if.sv
// Result channel of the periodic task dispatcher: valid, ready and payload.
// Depends on ptd_pkg for the field types.
interface ptd_rsp_if
    import ptd_pkg::*;
();
    logic      valid;
    logic      ready;
    status_t   status;
    slot_num_t slot;
    logic      last;

    modport source (output valid, status, slot, last, input ready);
    modport sink   (input valid, status, slot, last, output ready);
endinterface

### sv/periodic_task_dispatcher_top.sv
// Top level of the periodic task dispatcher: slot flags in flip-flops, period and
// last-run times in two synchronous memories. Depends on ptd_pkg, ptd_req_if, ptd_rsp_if.
//
// A request on the request channel carries one command: add, remove, tick or
// dispatch. Each request gives one or more results on the result channel; the
// final result of a request has last set. Requests are handled one at a time:
// request.ready is high only while the block is idle, and it stays low from an
// accepted request until its final result has entered the output register.
// Add and remove register their result, which S_EMIT then moves into the output
// register. Tick reads the period and last-run memories one slot a cycle.
// Dispatch visits one slot a cycle and emits at most one result a cycle while
// the output register is free; at a ready slot it waits while that register is
// full. An empty dispatch gives a single result of status none through S_EMIT.
// A new request can be accepted while the last result still waits in the
// output register.
// When the receiver holds result.ready low, the output register holds its
// result and the dispatch scan waits, so no result is lost or repeated.
// Reset clears every slot: all slots are free, disabled and not ready. The
// memories need no clearing pass, as add rewrites a slot's whole entry.
module periodic_task_dispatcher_top
    import ptd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ptd_req_if.sink  request,
    ptd_rsp_if.source result
);

    typedef enum logic [1:0] {S_IDLE, S_TICK, S_DISP, S_EMIT} state_t;

    state_t                  state_reg, state_next;
    time_t                   now_reg, now_next;
    slot_idx_t               scan_reg, scan_next;
    logic                    issued_reg, issued_next;
    logic                    tv_reg, tv_next;
    slot_idx_t               tidx_reg, tidx_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    status_t                 res_status_reg, res_status_next;
    slot_num_t               res_slot_reg, res_slot_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    slot_num_t               out_slot_reg, out_slot_next;
    logic                    out_last_reg, out_last_next;

    logic [TASK_SLOTS-1:0]   used_reg, used_next;
    logic [TASK_SLOTS-1:0]   enabled_reg, enabled_next;
    logic [TASK_SLOTS-1:0]   ready_reg, ready_next;
    mode_t [TASK_SLOTS-1:0]  mode_reg, mode_next;

    time_t                   period_mem [TASK_SLOTS];
    time_t                   last_mem [TASK_SLOTS];
    time_t                   period_rd_reg;
    time_t                   last_rd_reg;

    logic                    p_we;
    slot_idx_t               p_addr;
    time_t                   p_data;
    logic                    l_we;
    slot_idx_t               l_addr;
    time_t                   l_data;
    logic                    rd_en;
    slot_idx_t               rd_addr;

    logic                    out_free;
    logic [TASK_SLOTS-1:0]   qual_mask;
    logic                    more_above;
    logic                    free_found;
    slot_idx_t               free_idx;
    time_t                   tick_diff;
    logic                    sel_ok;
    logic                    emit_last;

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            qual_mask[i] = enabled_reg[i] &&
                           (ready_reg[i] || mode_reg[i] == MODE_BACKGROUND);
        end
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = slot_idx_t'(i);
            end
        end
    end

    assign more_above = ((qual_mask >> scan_reg) >> 1) != '0;
    assign tick_diff  = now_reg - last_rd_reg;
    assign sel_ok     = 32'(request.slot_select) < 32'(TASK_SLOTS);
    assign emit_last  = (cnt_reg == CNT_W'(MAX_OUT - 1)) || !more_above;

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        scan_next       = scan_reg;
        issued_next     = issued_reg;
        tv_next         = 1'b0;
        tidx_next       = tidx_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        used_next       = used_reg;
        enabled_next    = enabled_reg;
        ready_next      = ready_reg;
        mode_next       = mode_reg;
        p_we            = 1'b0;
        p_addr          = free_idx;
        p_data          = request.task_period;
        l_we            = 1'b0;
        l_addr          = free_idx;
        l_data          = '0;
        rd_en           = 1'b0;
        rd_addr         = scan_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    now_next = request.now;
                    case (request.cmd)
                        CMD_ADD:
                        begin
                            if (free_found)
                            begin
                                used_next[free_idx]    = 1'b1;
                                enabled_next[free_idx] = 1'b1;
                                ready_next[free_idx]   = 1'b0;
                                mode_next[free_idx]    = request.run_mode;
                                p_we                   = 1'b1;
                                l_we                   = 1'b1;
                                res_status_next        = ST_OK;
                                res_slot_next          = slot_num_t'(free_idx);
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                                res_slot_next   = '0;
                            end
                            state_next = S_EMIT;
                        end
                        CMD_REMOVE:
                        begin
                            if (sel_ok)
                            begin
                                used_next[slot_idx_t'(request.slot_select)]    = 1'b0;
                                enabled_next[slot_idx_t'(request.slot_select)] = 1'b0;
                                ready_next[slot_idx_t'(request.slot_select)]   = 1'b0;
                                mode_next[slot_idx_t'(request.slot_select)]    =
                                    MODE_PERIODIC;
                                res_status_next = ST_OK;
                                res_slot_next   = request.slot_select[2:0];
                            end
                            else
                            begin
                                res_status_next = ST_BAD_SLOT;
                                res_slot_next   = '0;
                            end
                            state_next = S_EMIT;
                        end
                        CMD_TICK:
                        begin
                            scan_next   = '0;
                            issued_next = 1'b0;
                            state_next  = S_TICK;
                        end
                        default:
                        begin
                            scan_next  = '0;
                            cnt_next   = '0;
                            state_next = S_DISP;
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                if (!issued_reg)
                begin
                    rd_en     = 1'b1;
                    tv_next   = 1'b1;
                    tidx_next = scan_reg;
                    if (scan_reg == LAST_IDX)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + slot_idx_t'(1);
                    end
                end
                if (tv_reg)
                begin
                    if (used_reg[tidx_reg] && mode_reg[tidx_reg] != MODE_BACKGROUND &&
                        tick_diff > period_rd_reg)
                    begin
                        ready_next[tidx_reg] = 1'b1;
                    end
                    if (tidx_reg == LAST_IDX)
                    begin
                        res_status_next = ST_OK;
                        res_slot_next   = '0;
                        state_next      = S_EMIT;
                    end
                end
            end

            S_DISP:
            begin
                if (qual_mask[scan_reg])
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OK;
                        out_slot_next   = slot_num_t'(scan_reg);
                        out_last_next   = emit_last;
                        l_we            = 1'b1;
                        l_addr          = scan_reg;
                        l_data          = now_reg;
                        if (mode_reg[scan_reg] != MODE_BACKGROUND)
                        begin
                            ready_next[scan_reg] = 1'b0;
                        end
                        if (mode_reg[scan_reg] == MODE_ONE_SHOT)
                        begin
                            enabled_next[scan_reg] = 1'b0;
                        end
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (emit_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            scan_next = scan_reg + slot_idx_t'(1);
                        end
                    end
                end
                else if (scan_reg == LAST_IDX)
                begin
                    res_status_next = ST_NONE;
                    res_slot_next   = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + slot_idx_t'(1);
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            tv_reg        <= 1'b0;
            scan_reg      <= '0;
            tidx_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
            enabled_reg   <= '0;
            ready_reg     <= '0;
            mode_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            tv_reg        <= tv_next;
            scan_reg      <= scan_next;
            tidx_reg      <= tidx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
            enabled_reg   <= enabled_next;
            ready_reg     <= ready_next;
            mode_reg      <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            period_mem[p_addr] <= p_data;
        end
        if (l_we)
        begin
            last_mem[l_addr] <= l_data;
        end
        if (rd_en)
        begin
            period_rd_reg <= period_mem[rd_addr];
            last_rd_reg   <= last_mem[rd_addr];
        end
    end

    assign request.ready = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.slot   = out_slot_reg;
    assign result.last   = out_last_reg;

endmodule

### sv/ptd_checker.sv
// Port-level checks for the periodic task dispatcher, bound to its top level.
// Depends on ptd_pkg and periodic_task_dispatcher_top.
module ptd_checker
    import ptd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      res_valid,
    input logic      res_ready,
    input status_t   res_status,
    input slot_num_t res_slot,
    input logic      res_last
);

    // Requests are handled one at a time.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while the previous one was in progress");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_OK |-> res_last)
        else $error("error or empty result is not the final one");

    a_error_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_OK |-> res_slot == '0)
        else $error("error or empty result carries a slot number");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) &&
        $stable(res_slot) && $stable(res_last))
        else $error("stalled result changed");

endmodule

bind periodic_task_dispatcher_top ptd_checker u_ptd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_slot   (result.slot),
    .res_last   (result.last)
);
